/* sv/rosi_pkg.sv */
// Package for the ray versus oriented box slab test unit.
// Holds payload structs and configuration register codes; depends on nothing.
package rosi_pkg;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 3;

  // Width of the distance field.
  localparam int DIST_W = 31;

  // Configuration register codes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5
  } cfg_reg_t;

  // One oriented box.
  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic [30:0]        half_x;
    logic [30:0]        half_y;
    logic [30:0]        half_z;
  } box_t;

  // One test result.
  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] distance;
  } res_t;

endpackage

/* sv/ray_obb_slab_intersect_unit.sv */
// Top level of the ray versus oriented box slab test unit.
// Depends on rosi_pkg for payload types and register codes.
// Throughput: one box per cycle while the skid register is empty; the six slab
// dividers are pipelined one quotient bit per stage, and their depth
// (55 + COORD_FRAC_BITS) sets latency.
// Reset (synchronous, active high) clears all valid bits and loads the ray
// registers with origin (0, 0, 0) and direction (65536, 0, 0).
module ray_obb_slab_intersect_unit #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rosi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data,
  input  logic                             box_valid,
  output logic                             box_ready,
  input  rosi_pkg::box_t                   box_data,
  output logic                             hit_valid,
  input  logic                             hit_ready,
  output rosi_pkg::res_t                   hit_data
);
  import rosi_pkg::*;

  localparam int AXW = 20;
  localparam int PW  = 33;
  localparam int EPW = AXW + PW;
  localparam int FPW = AXW + 32;
  localparam int EW  = 55;
  localparam int FW  = 54;
  localparam int UW  = EW;
  localparam int DW  = FW;
  localparam int QW  = 62;
  localparam int NW  = UW + COORD_FRAC_BITS;
  localparam logic [DW-1:0] PAR_EPS =
    DW'((64'd1 << (COORD_FRAC_BITS + 14)) / 64'd100000);
  localparam logic signed [35:0] ONE_Q28 = 36'sd268435456;
  localparam logic signed [63:0] T_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [63:0] T_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] DIST_MAX = 64'sd2147483647;

  // Rounds a Q.28 matrix entry to Q.14 by adding one half and flooring.
  function automatic logic signed [AXW-1:0] round_q14(input logic signed [35:0] v);
    logic signed [35:0] s;
    s = v + 36'sd8192;
    return s[14+AXW-1:14];
  endfunction

  // Forms a signed slab distance from quotient, saturation and sign.
  function automatic logic signed [63:0] slab_t(input logic sat, input logic [QW-1:0] q,
                                               input logic neg);
    logic signed [63:0] m;
    m = sat ? {2'b01, {62{1'b0}}} : {2'b00, q};
    return neg ? -m : m;
  endfunction

  logic en;
  logic skid_valid;
  res_t skid_data;

  // Ray configuration registers.
  logic signed [31:0] org_x, org_y, org_z, dir_x, dir_y, dir_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      org_x <= '0;
      org_y <= '0;
      org_z <= '0;
      dir_x <= 32'sd65536;
      dir_y <= '0;
      dir_z <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X: org_x <= cfg_data;
        REG_ORIGIN_Y: org_y <= cfg_data;
        REG_ORIGIN_Z: org_z <= cfg_data;
        REG_DIR_X:    dir_x <= cfg_data;
        REG_DIR_Y:    dir_y <= cfg_data;
        REG_DIR_Z:    dir_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the skid register is empty.
  assign en        = !skid_valid;
  assign box_ready = en;

  // Stage 1: offset from the ray origin and quaternion products.
  logic                v1;
  logic signed [PW-1:0] p1 [3];
  logic [30:0]         h1 [3];
  logic signed [31:0]  pxx1, pyy1, pzz1, pxy1, pxz1, pyz1, pwx1, pwy1, pwz1;
  logic signed [15:0]  qw, qx, qy, qz;

  assign qw = box_data.quat_w;
  assign qx = box_data.quat_x;
  assign qy = box_data.quat_y;
  assign qz = box_data.quat_z;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= box_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1[0] <= PW'(box_data.center_x) - PW'(org_x);
      p1[1] <= PW'(box_data.center_y) - PW'(org_y);
      p1[2] <= PW'(box_data.center_z) - PW'(org_z);
      h1[0] <= box_data.half_x;
      h1[1] <= box_data.half_y;
      h1[2] <= box_data.half_z;
      pxx1  <= qx * qx;
      pyy1  <= qy * qy;
      pzz1  <= qz * qz;
      pxy1  <= qx * qy;
      pxz1  <= qx * qz;
      pyz1  <= qy * qz;
      pwx1  <= qw * qx;
      pwy1  <= qw * qy;
      pwz1  <= qw * qz;
    end
  end

  // Stage 2: rotation matrix columns, rounded to Q.14.
  logic                  v2;
  logic signed [AXW-1:0] ax2 [3][3];
  logic signed [PW-1:0]  p2 [3];
  logic [30:0]           h2 [3];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax2[0][0] <= round_q14(ONE_Q28 - ((36'(pyy1) + 36'(pzz1)) <<< 1));
      ax2[0][1] <= round_q14((36'(pxy1) + 36'(pwz1)) <<< 1);
      ax2[0][2] <= round_q14((36'(pxz1) - 36'(pwy1)) <<< 1);
      ax2[1][0] <= round_q14((36'(pxy1) - 36'(pwz1)) <<< 1);
      ax2[1][1] <= round_q14(ONE_Q28 - ((36'(pxx1) + 36'(pzz1)) <<< 1));
      ax2[1][2] <= round_q14((36'(pyz1) + 36'(pwx1)) <<< 1);
      ax2[2][0] <= round_q14((36'(pxz1) + 36'(pwy1)) <<< 1);
      ax2[2][1] <= round_q14((36'(pyz1) - 36'(pwx1)) <<< 1);
      ax2[2][2] <= round_q14(ONE_Q28 - ((36'(pxx1) + 36'(pyy1)) <<< 1));
      p2 <= p1;
      h2 <= h1;
    end
  end

  // Stage 3: products of each axis with the offset and with the direction.
  logic                  v3;
  logic signed [EPW-1:0] ep3 [3][3];
  logic signed [FPW-1:0] fp3 [3][3];
  logic [30:0]           h3 [3];

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          ep3[i][j] <= ax2[i][j] * p2[j];
        end
        fp3[i][0] <= ax2[i][0] * dir_x;
        fp3[i][1] <= ax2[i][1] * dir_y;
        fp3[i][2] <= ax2[i][2] * dir_z;
      end
      h3 <= h2;
    end
  end

  // Stage 4: dot products e and f per axis.
  logic                 v4;
  logic signed [EW-1:0] e4 [3];
  logic signed [FW-1:0] f4 [3];
  logic [30:0]          h4 [3];

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e4[i] <= EW'(ep3[i][0]) + EW'(ep3[i][1]) + EW'(ep3[i][2]);
        f4[i] <= FW'(fp3[i][0]) + FW'(fp3[i][1]) + FW'(fp3[i][2]);
      end
      h4 <= h3;
    end
  end

  // Divider pipeline storage; row 0 is loaded from stage 4.
  logic            dv   [NW+1];
  logic [2:0]      dpar [NW+1];
  logic [2:0]      dpok [NW+1];
  logic [UW-1:0]   dnum [NW+1][6];
  logic [DW-1:0]   dden [NW+1][6];
  logic [DW-1:0]   drem [NW+1][6];
  logic [QW-1:0]   dq   [NW+1][6];
  logic            dsat [NW+1][6];
  logic            dneg [NW+1][6];
  logic [2:0]      par_c, pok_c;

  // Slab numerators, divisor magnitudes and the parallel-axis checks.
  for (genvar i = 0; i < 3; i++) begin : g_prep
    logic signed [EW-1:0] hs, n1, n2;
    logic [DW-1:0]        fmag;

    assign hs   = EW'({h4[i], 14'b0});
    assign n1   = e4[i] + hs;
    assign n2   = e4[i] - hs;
    assign fmag = f4[i][FW-1] ? DW'(-f4[i]) : DW'(f4[i]);
    assign par_c[i] = fmag <= PAR_EPS;
    assign pok_c[i] = !((e4[i] < -hs) || (e4[i] > hs));

    always_ff @(posedge clk) begin
      if (en) begin
        dnum[0][2*i]   <= n1[EW-1] ? UW'(-n1) : UW'(n1);
        dnum[0][2*i+1] <= n2[EW-1] ? UW'(-n2) : UW'(n2);
        dden[0][2*i]   <= fmag;
        dden[0][2*i+1] <= fmag;
        drem[0][2*i]   <= '0;
        drem[0][2*i+1] <= '0;
        dq[0][2*i]     <= '0;
        dq[0][2*i+1]   <= '0;
        dsat[0][2*i]   <= 1'b0;
        dsat[0][2*i+1] <= 1'b0;
        dneg[0][2*i]   <= n1[EW-1] ^ f4[i][FW-1];
        dneg[0][2*i+1] <= n2[EW-1] ^ f4[i][FW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (en) dv[0] <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dpar[0] <= par_c;
      dpok[0] <= pok_c;
    end
  end

  // Restoring division, one quotient bit per stage, six lanes side by side.
  for (genvar k = 0; k < NW; k++) begin : g_div
    localparam int QI = NW - 1 - k;

    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else if (en) dv[k+1] <= dv[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dpar[k+1] <= dpar[k];
        dpok[k+1] <= dpok[k];
      end
    end

    for (genvar l = 0; l < 6; l++) begin : g_lane
      logic        nbit;
      logic [DW:0] trial, diff;
      logic        ge;

      if (QI >= COORD_FRAC_BITS) begin : g_nbit
        assign nbit = dnum[k][l][QI-COORD_FRAC_BITS];
      end else begin : g_zero
        assign nbit = 1'b0;
      end

      assign trial = {drem[k][l], nbit};
      assign diff  = trial - {1'b0, dden[k][l]};
      assign ge    = trial >= {1'b0, dden[k][l]};

      always_ff @(posedge clk) begin
        if (en) begin
          dnum[k+1][l] <= dnum[k][l];
          dden[k+1][l] <= dden[k][l];
          dneg[k+1][l] <= dneg[k][l];
          drem[k+1][l] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
      end

      // Quotient bits from bit 62 up only mark saturation.
      if (QI < QW) begin : g_qbit
        always_ff @(posedge clk) begin
          if (en) begin
            dq[k+1][l]   <= dq[k][l] | (QW'(ge) << QI);
            dsat[k+1][l] <= dsat[k][l];
          end
        end
      end else begin : g_sat
        always_ff @(posedge clk) begin
          if (en) begin
            dq[k+1][l]   <= dq[k][l];
            dsat[k+1][l] <= dsat[k][l] | ge;
          end
        end
      end
    end
  end

  // Stage after division: signed slab distances, ordered near and far.
  logic               v6;
  logic signed [63:0] lo6 [3];
  logic signed [63:0] hi6 [3];
  logic [2:0]         par6, pok6;
  logic signed [63:0] lo_c [3];
  logic signed [63:0] hi_c [3];

  always_comb begin
    logic signed [63:0] t1, t2;
    for (int i = 0; i < 3; i++) begin
      t1 = slab_t(dsat[NW][2*i], dq[NW][2*i], dneg[NW][2*i]);
      t2 = slab_t(dsat[NW][2*i+1], dq[NW][2*i+1], dneg[NW][2*i+1]);
      lo_c[i] = (t1 > t2) ? t2 : t1;
      hi_c[i] = (t1 > t2) ? t1 : t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= dv[NW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo6  <= lo_c;
      hi6  <= hi_c;
      par6 <= dpar[NW];
      pok6 <= dpok[NW];
    end
  end

  // Interval narrowing over the non-parallel axes.
  logic               v7, ok7;
  logic signed [63:0] tmin7, tmax7;
  logic signed [63:0] tmin_c, tmax_c;

  always_comb begin
    tmin_c = T_MIN;
    tmax_c = T_MAX;
    for (int i = 0; i < 3; i++) begin
      if (!par6[i]) begin
        if (lo6[i] > tmin_c) tmin_c = lo6[i];
        if (hi6[i] < tmax_c) tmax_c = hi6[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tmin7 <= tmin_c;
      tmax7 <= tmax_c;
      ok7   <= &(~par6 | pok6);
    end
  end

  // Hit decision and distance selection with clamping.
  res_t               res_next;
  logic               hit_c;
  logic signed [63:0] tsel;
  logic [DIST_W-1:0]  dist_c;

  always_comb begin
    hit_c = ok7 && !(tmin7 > tmax7) && !(tmax7 < 0);
    tsel  = (tmin7 > 0) ? tmin7 : tmax7;
    if (tsel < 0) dist_c = '0;
    else if (tsel > DIST_MAX) dist_c = '1;
    else dist_c = tsel[DIST_W-1:0];
    res_next.hit      = hit_c;
    res_next.distance = hit_c ? dist_c : '0;
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (en) begin
      if (v7) begin
        if (!hit_valid || hit_ready) hit_valid <= 1'b1;
        else skid_valid <= 1'b1;
      end else if (hit_ready) begin
        hit_valid <= 1'b0;
      end
    end else if (hit_ready) begin
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (v7) begin
        if (!hit_valid || hit_ready) hit_data <= res_next;
        else skid_data <= res_next;
      end
    end else if (hit_ready) begin
      hit_data <= skid_data;
    end
  end

endmodule

/* sv/rosi_chk.sv */
// Port-level checker for the ray versus oriented box slab test unit.
// Depends on rosi_pkg for payload types; bound to the top level below.
module rosi_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [rosi_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [31:0]                    cfg_data,
  input logic                           box_valid,
  input logic                           box_ready,
  input rosi_pkg::box_t                 box_data,
  input logic                           hit_valid,
  input logic                           hit_ready,
  input rosi_pkg::res_t                 hit_data
);
  import rosi_pkg::*;

  // No result is shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !hit_valid)
    else $error("result valid right after reset");

  // A stalled result holds until its transfer.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    hit_valid && !hit_ready |=> hit_valid && $stable(hit_data))
    else $error("stalled result changed");

  // A miss always reports a zero distance.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    hit_valid && !hit_data.hit |-> hit_data.distance == '0)
    else $error("miss with nonzero distance");

  // Input backpressure only follows a stalled result.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !box_ready |-> $past(hit_valid && !hit_ready))
    else $error("input stalled without output stall");

endmodule

bind ray_obb_slab_intersect_unit rosi_chk u_rosi_chk (.*);

/* bench/ray_obb_slab_intersect_unit_test.sv */
// Self-checking bench for the ray versus oriented box slab test unit.
// Depends on rosi_pkg and ray_obb_slab_intersect_unit; predicts each hit result.
`timescale 1ns / 1ps

module ray_obb_slab_intersect_unit_test;
  import rosi_pkg::*;

  localparam int FRAC = 16;
  localparam longint PAR_LIMIT = (64'sd1 <<< (FRAC + 14)) / 100000;
  localparam longint T_LIMIT = 64'sd1 <<< 62;
  localparam longint DIST_TOP = 64'sh7FFFFFFF;
  localparam int LATENCY = 62 + FRAC;
  localparam int WATCHDOG = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic box_valid = 1'b0;
  logic box_ready;
  box_t box_data = '0;
  logic hit_valid;
  logic hit_ready = 1'b0;
  res_t hit_data;

  // Ray held by the predictor.
  longint ray_org [3];
  longint ray_dir [3];

  box_t box_pending [$];
  res_t hit_expected [$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet_phase = 1'b0;
  bit box_took = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  ray_obb_slab_intersect_unit #(.COORD_FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .box_valid(box_valid), .box_ready(box_ready), .box_data(box_data),
    .hit_valid(hit_valid), .hit_ready(hit_ready), .hit_data(hit_data)
  );

  always #2 clk = ~clk;

  function automatic longint floor_q14(longint v);
    return (v + (64'sd1 <<< 13)) >>> 14;
  endfunction

  // Slab distance in Q.F, truncated toward zero and held at 2^62.
  function automatic longint slab_distance(longint n, longint d);
    bit neg;
    longint unsigned un, ud, q, r;
    neg = (n < 0) != (d < 0);
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = un / ud;
    r = un % ud;
    if (q >= (64'd1 << (62 - FRAC))) begin
      q = T_LIMIT;
    end else begin
      for (int k = 0; k < FRAC; k++) begin
        r = r << 1;
        q = q << 1;
        if (r >= ud) begin
          r = r - ud;
          q = q | 64'd1;
        end
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic res_t predict_hit(box_t b);
    longint p [3], hx [3], m [3][3];
    longint qw, qx, qy, qz, tmin, tmax, t, e, f, af, t1, t2, tmp;
    bit hit;
    res_t r;
    qw = b.quat_w; qx = b.quat_x; qy = b.quat_y; qz = b.quat_z;
    p[0] = longint'(b.center_x) - ray_org[0];
    p[1] = longint'(b.center_y) - ray_org[1];
    p[2] = longint'(b.center_z) - ray_org[2];
    hx[0] = longint'({33'd0, b.half_x}) <<< 14;
    hx[1] = longint'({33'd0, b.half_y}) <<< 14;
    hx[2] = longint'({33'd0, b.half_z}) <<< 14;
    m[0][0] = floor_q14((64'sd1 <<< 28) - 2 * (qy * qy + qz * qz));
    m[0][1] = floor_q14(2 * (qx * qy + qw * qz));
    m[0][2] = floor_q14(2 * (qx * qz - qw * qy));
    m[1][0] = floor_q14(2 * (qx * qy - qw * qz));
    m[1][1] = floor_q14((64'sd1 <<< 28) - 2 * (qx * qx + qz * qz));
    m[1][2] = floor_q14(2 * (qy * qz + qw * qx));
    m[2][0] = floor_q14(2 * (qx * qz + qw * qy));
    m[2][1] = floor_q14(2 * (qy * qz - qw * qx));
    m[2][2] = floor_q14((64'sd1 <<< 28) - 2 * (qx * qx + qy * qy));
    tmin = 64'sh8000000000000000;
    tmax = 64'sh7FFFFFFFFFFFFFFF;
    hit = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (hit) begin
        e = m[i][0] * p[0] + m[i][1] * p[1] + m[i][2] * p[2];
        f = m[i][0] * ray_dir[0] + m[i][1] * ray_dir[1] + m[i][2] * ray_dir[2];
        af = (f < 0) ? -f : f;
        if (af > PAR_LIMIT) begin
          t1 = slab_distance(e + hx[i], f);
          t2 = slab_distance(e - hx[i], f);
          if (t1 > t2) begin
            tmp = t1; t1 = t2; t2 = tmp;
          end
          if (t1 > tmin) tmin = t1;
          if (t2 < tmax) tmax = t2;
          if (tmin > tmax || tmax < 0) hit = 1'b0;
        end else if (e < -hx[i] || e > hx[i]) begin
          hit = 1'b0;
        end
      end
    end
    r = '0;
    if (hit) begin
      t = (tmin > 0) ? tmin : tmax;
      if (t < 0) t = 0;
      if (t > DIST_TOP) t = DIST_TOP;
      r.hit = 1'b1;
      r.distance = t[30:0];
    end
    return r;
  endfunction

  // Box and ready driver: a new transfer is offered, and hit_ready set, at the falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (!box_valid || box_took) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          box_valid <= 1'b0;
        end else if (box_pending.size() > 0) begin
          box_data <= box_pending.pop_front();
          box_valid <= 1'b1;
          if (!quiet_phase && $urandom_range(0, 9) == 0)
            send_gap <= $urandom_range(1, 14);
        end else begin
          box_valid <= 1'b0;
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        hit_ready <= 1'b0;
      end else begin
        hit_ready <= 1'b1;
        if (!quiet_phase && $urandom_range(0, 9) == 0)
          recv_gap <= $urandom_range(1, 14);
      end
    end
  end

  // Input sampling, result monitor and watchdog.
  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      box_took <= box_valid && box_ready;
      if (box_valid && box_ready) begin
        hit_expected.push_back(predict_hit(box_data));
      end
      if ((box_valid && box_ready) || (hit_valid && hit_ready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (box_valid || hit_expected.size() > 0 || cfg_valid) begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t: watchdog expired", $time);
        $display("Test completed with failures");
        $finish;
      end
      if (hit_valid && hit_ready) begin
        if (hit_expected.size() == 0) begin
          $display("%0t: unexpected result %p", $time, hit_data);
          errors <= errors + 1;
        end else begin
          want = hit_expected.pop_front();
          if (want.hit !== hit_data.hit || want.distance !== hit_data.distance) begin
            $display("%0t: expected hit=%0d distance=%0d, got hit=%0d distance=%0d",
                     $time, want.hit, want.distance, hit_data.hit, hit_data.distance);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ORIGIN_X: ray_org[0] = longint'($signed(value));
      REG_ORIGIN_Y: ray_org[1] = longint'($signed(value));
      REG_ORIGIN_Z: ray_org[2] = longint'($signed(value));
      REG_DIR_X:    ray_dir[0] = longint'($signed(value));
      REG_DIR_Y:    ray_dir[1] = longint'($signed(value));
      default:      ray_dir[2] = longint'($signed(value));
    endcase
  endtask

  task automatic set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                         logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
  endtask

  // Block until every queued box has gone in and every result has come back.
  task automatic drain();
    while (box_pending.size() > 0 || box_valid || hit_expected.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_quat_part();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // Mostly unit quaternions scaled from a random rotation; some raw values.
  function automatic box_t rand_box(int spread);
    box_t b;
    real w, x, y, z, n;
    b.center_x = $signed($urandom_range(0, 2 * spread)) - spread;
    b.center_y = $signed($urandom_range(0, 2 * spread)) - spread;
    b.center_z = $signed($urandom_range(0, 2 * spread)) - spread;
    if ($urandom_range(0, 4) == 0) begin
      b.quat_w = rand_quat_part(); b.quat_x = rand_quat_part();
      b.quat_y = rand_quat_part(); b.quat_z = rand_quat_part();
    end else begin
      w = $itor($signed($urandom_range(0, 2000)) - 1000);
      x = $itor($signed($urandom_range(0, 2000)) - 1000);
      y = $itor($signed($urandom_range(0, 2000)) - 1000);
      z = $itor($signed($urandom_range(0, 2000)) - 1000);
      n = $sqrt(w * w + x * x + y * y + z * z) + 1.0;
      b.quat_w = 16'($rtoi(w / n * 16384.0)); b.quat_x = 16'($rtoi(x / n * 16384.0));
      b.quat_y = 16'($rtoi(y / n * 16384.0)); b.quat_z = 16'($rtoi(z / n * 16384.0));
    end
    if ($urandom_range(0, 9) == 0) begin
      b.half_x = 31'($urandom); b.half_y = 31'($urandom); b.half_z = 31'($urandom);
    end else begin
      b.half_x = 31'($urandom_range(0, spread)); b.half_y = 31'($urandom_range(0, spread));
      b.half_z = 31'($urandom_range(0, spread));
    end
    return b;
  endfunction

  function automatic box_t make_box(int cx, int cy, int cz, int qw, int qx, int qy,
                                    int qz, int hx, int hy, int hz);
    box_t b;
    b.center_x = cx; b.center_y = cy; b.center_z = cz;
    b.quat_w = 16'(qw); b.quat_x = 16'(qx); b.quat_y = 16'(qy); b.quat_z = 16'(qz);
    b.half_x = 31'(hx); b.half_y = 31'(hy); b.half_z = 31'(hz);
    return b;
  endfunction

  initial begin
    box_t b;
    ray_org = '{0, 0, 0};
    ray_dir = '{65536, 0, 0};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed boxes with the reset ray along +x.
    box_pending.push_back(make_box(10 << 16, 0, 0, 16384, 0, 0, 0, 65536, 65536, 65536));
    box_pending.push_back(make_box(-(10 << 16), 0, 0, 16384, 0, 0, 0, 65536, 65536, 65536));
    box_pending.push_back(make_box(0, 0, 0, 16384, 0, 0, 0, 65536, 65536, 65536));
    box_pending.push_back(make_box(10 << 16, 5 << 16, 0, 16384, 0, 0, 0, 65536, 65536,
                                   65536));
    box_pending.push_back(make_box(10 << 16, 0, 0, 11585, 0, 0, 11585, 65536, 65536,
                                   65536));
    box_pending.push_back(make_box(10 << 16, 0, 0, -16384, 0, 0, 0, 0, 0, 0));
    box_pending.push_back(make_box(10 << 16, 0, 0, 0, 16384, 0, 0, 65536, 65536, 65536));
    box_pending.push_back(make_box(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16384, 16384,
                                   -16384, -16384, 31'h7FFFFFFF, 31'h7FFFFFFF,
                                   31'h7FFFFFFF));
    box_pending.push_back(make_box(32'h80000000, 32'h7FFFFFFF, 32'h80000000, -16384,
                                   -16384, 16384, 16384, 0, 31'h7FFFFFFF, 0));
    box_pending.push_back(make_box(5, 0, 0, 16384, 0, 0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF,
                                   31'h7FFFFFFF));
    box_pending.push_back(make_box(0, 0, 0, 0, 0, 0, 0, 65536, 65536, 65536));
    box_pending.push_back(make_box(-1, -1, -1, -1, -1, -1, -1, 31'h55555555, 31'h2AAAAAAA,
                                   1));
    drain();

    // All axes near parallel: zero direction, inside and outside the box.
    set_ray(0, 0, 0, 0, 0, 0);
    box_pending.push_back(make_box(0, 0, 0, 16384, 0, 0, 0, 65536, 65536, 65536));
    box_pending.push_back(make_box(5 << 16, 0, 0, 16384, 0, 0, 0, 65536, 65536, 65536));
    drain();

    // Extreme ray values give huge slab distances.
    set_ray(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1 << 14, 32'h7FFFFFFF, 32'h80000000);
    box_pending.push_back(make_box(0, 0, 0, 16384, 0, 0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF,
                                   31'h7FFFFFFF));
    box_pending.push_back(make_box(32'h7FFFFFFF, 0, 0, 16384, 0, 0, 0, 1, 1, 1));
    drain();

    // Random phases over several rays; the last phase runs without idling.
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) begin
        set_ray(0, 0, 0, 1, 32'hFFFFFFFF, 0);
      end else begin
        set_ray($signed($urandom_range(0, 40 << 16)) - (20 << 16),
                $signed($urandom_range(0, 40 << 16)) - (20 << 16),
                $signed($urandom_range(0, 40 << 16)) - (20 << 16),
                $signed($urandom_range(0, 4 << 16)) - (2 << 16),
                $signed($urandom_range(0, 4 << 16)) - (2 << 16),
                (ph == 3) ? $urandom : $signed($urandom_range(0, 4 << 16)) - (2 << 16));
      end
      quiet_phase = (ph == 4);
      for (int n = 0; n < 110; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          b = rand_box(32'h7FFFFFFF);
          b.center_x = $urandom; b.center_y = $urandom; b.center_z = $urandom;
        end else begin
          b = rand_box(30 << 16);
        end
        box_pending.push_back(b);
      end
      drain();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
